// ----- design/ocpr_pkg.sv -----
// Shared types and constants for the OFDM cyclic prefix remover.
package ocpr_pkg;

   localparam int unsigned FFT_WIDTH = 12;
   localparam int unsigned CP_WIDTH = 9;
   localparam int unsigned POS_WIDTH = 12;
   localparam int unsigned LEN_WIDTH = 13;
   localparam int unsigned SLOT_WIDTH = 3;
   localparam int unsigned SYMNO_WIDTH = 8;
   localparam int unsigned SAMPLE_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH = 12;

   localparam logic [SLOT_WIDTH-1:0] SYMS_PER_SLOT = 3'd7;
   localparam logic [SYMNO_WIDTH-1:0] SYMS_PER_FRAME = 8'd140;
   localparam logic [LEN_WIDTH-1:0] MAX_SYM_LEN = 13'd4096;

   localparam logic [FFT_WIDTH-1:0] FFT_LENGTH_RESET = 12'd2048;
   localparam logic [CP_WIDTH-1:0] CP_NORMAL_RESET = 9'd144;
   localparam logic [CP_WIDTH-1:0] CP_FIRST_RESET = 9'd160;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FFT_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CP_NORMAL = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CP_FIRST = 2'd2;

   typedef struct packed {
      logic [FFT_WIDTH-1:0] fft_length;
      logic [CP_WIDTH-1:0] cp_normal;
      logic [CP_WIDTH-1:0] cp_first;
   } cfg_type;

   typedef struct packed {
      logic keep;
      logic first;
      logic last;
      logic slot_start;
      logic sync_lost;
      logic synced;
      logic [SYMNO_WIDTH-1:0] symbol_number;
   } sample_tag_type;

endpackage

// ----- design/ocpr_csr.sv -----
// Configuration registers of the cyclic prefix remover.
module ocpr_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [ocpr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ocpr_pkg::CSR_DATA_WIDTH-1:0] csr_write_data,
   output ocpr_pkg::cfg_type cfg
);
   import ocpr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FFT_LENGTH: cfg_in.fft_length = csr_write_data[FFT_WIDTH-1:0];
            CSR_CP_NORMAL: cfg_in.cp_normal = csr_write_data[CP_WIDTH-1:0];
            CSR_CP_FIRST: cfg_in.cp_first = csr_write_data[CP_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fft_length <= FFT_LENGTH_RESET;
         cfg_ff.cp_normal <= CP_NORMAL_RESET;
         cfg_ff.cp_first <= CP_FIRST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/ocpr_framer.sv -----
// Frame, slot and symbol position counters with sample classification.
module ocpr_framer (
   input  logic clock,
   input  logic reset,
   input  ocpr_pkg::cfg_type cfg,
   input  logic advance,
   input  logic frame_mark,
   output ocpr_pkg::sample_tag_type tag
);
   import ocpr_pkg::*;

   logic locked_ff, locked_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [SLOT_WIDTH-1:0] slot_idx_ff, slot_idx_in;
   logic [SYMNO_WIDTH-1:0] frame_sym_ff, frame_sym_in;

   logic active;
   logic [POS_WIDTH-1:0] pos_cur;
   logic [SLOT_WIDTH-1:0] slot_idx_cur;
   logic [SYMNO_WIDTH-1:0] frame_sym_cur;
   logic [CP_WIDTH-1:0] cp;
   logic [LEN_WIDTH-1:0] len_raw, len, pos_ext, pos_next, cp_ext;
   logic in_body, sym_end;

   always_comb begin
      active = locked_ff | frame_mark;
      pos_cur = frame_mark ? '0 : pos_ff;
      slot_idx_cur = frame_mark ? '0 : slot_idx_ff;
      frame_sym_cur = frame_mark ? '0 : frame_sym_ff;

      cp = (slot_idx_cur == '0) ? cfg.cp_first : cfg.cp_normal;
      cp_ext = {{(LEN_WIDTH-CP_WIDTH){1'b0}}, cp};
      len_raw = cp_ext + {{(LEN_WIDTH-FFT_WIDTH){1'b0}}, cfg.fft_length};
      len = (len_raw > MAX_SYM_LEN) ? MAX_SYM_LEN : len_raw;
      pos_ext = {{(LEN_WIDTH-POS_WIDTH){1'b0}}, pos_cur};
      pos_next = pos_ext + LEN_WIDTH'(1);
      in_body = (pos_ext >= cp_ext) && (pos_ext < len);
      sym_end = (pos_next >= len);

      tag.keep = active & in_body;
      tag.first = active & in_body & (pos_ext == cp_ext);
      tag.last = active & in_body & (pos_next == len);
      tag.slot_start = active & in_body & (pos_ext == cp_ext) & (slot_idx_cur == '0);
      tag.sync_lost = locked_ff & frame_mark &
                      ((pos_ff != '0) || (slot_idx_ff != '0) || (frame_sym_ff != '0));
      tag.synced = active;
      tag.symbol_number = active ? frame_sym_cur : '0;

      locked_in = locked_ff;
      pos_in = pos_ff;
      slot_idx_in = slot_idx_ff;
      frame_sym_in = frame_sym_ff;
      if (advance && active) begin
         locked_in = 1'b1;
         if (sym_end) begin
            pos_in = '0;
            slot_idx_in = (slot_idx_cur + SLOT_WIDTH'(1) >= SYMS_PER_SLOT) ? '0
                          : slot_idx_cur + SLOT_WIDTH'(1);
            frame_sym_in = (frame_sym_cur + SYMNO_WIDTH'(1) >= SYMS_PER_FRAME) ? '0
                           : frame_sym_cur + SYMNO_WIDTH'(1);
         end else begin
            pos_in = pos_next[POS_WIDTH-1:0];
            slot_idx_in = slot_idx_cur;
            frame_sym_in = frame_sym_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff <= 1'b0;
         pos_ff <= '0;
         slot_idx_ff <= '0;
         frame_sym_ff <= '0;
      end else begin
         locked_ff <= locked_in;
         pos_ff <= pos_in;
         slot_idx_ff <= slot_idx_in;
         frame_sym_ff <= frame_sym_in;
      end
   end

endmodule

// ----- design/ofdm_cyclic_prefix_remover.sv -----
// Top level of the OFDM cyclic prefix remover with frame alignment.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | sample_i, sample_q, frame_mark
//   rsp     | out       | rsp_valid/stall    | out_i, out_q, keep, symbol flags
//   csr     | in        | csr_write_enable   | csr_index, csr_write_data
//
// One transaction per clock sustained while rsp is not stalled; a req passes the input
// register, then the result register, to rsp_valid. Every request yields one response.
// Synchronous reset clears the counters and loads the default lengths.
// A stalled rsp holds the result; req stalls only while both registers are full.
module ofdm_cyclic_prefix_remover (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [ocpr_pkg::SAMPLE_WIDTH-1:0] req_sample_i,
   input  logic signed [ocpr_pkg::SAMPLE_WIDTH-1:0] req_sample_q,
   input  logic req_frame_mark,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [ocpr_pkg::SAMPLE_WIDTH-1:0] rsp_out_i,
   output logic signed [ocpr_pkg::SAMPLE_WIDTH-1:0] rsp_out_q,
   output logic rsp_keep,
   output logic [ocpr_pkg::SYMNO_WIDTH-1:0] rsp_symbol_number,
   output logic rsp_first_in_symbol,
   output logic rsp_last_in_symbol,
   output logic rsp_slot_start,
   output logic rsp_sync_lost,
   output logic rsp_synced,
   input  logic csr_write_enable,
   input  logic [ocpr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ocpr_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import ocpr_pkg::*;

   cfg_type cfg;
   sample_tag_type tag;

   logic in_valid_ff, in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] in_i_ff, in_q_ff;
   logic in_mark_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_i_ff, rsp_q_ff;
   sample_tag_type rsp_tag_ff;
   logic advance, req_take;

   ocpr_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .cfg(cfg)
   );

   ocpr_framer u_framer (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .advance(advance),
      .frame_mark(in_mark_ff),
      .tag(tag)
   );

   assign advance = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take = req_valid & ~req_stall;
   assign in_valid_in = req_take | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_i_ff <= req_sample_i;
         in_q_ff <= req_sample_q;
         in_mark_ff <= req_frame_mark;
      end
      if (advance) begin
         rsp_i_ff <= tag.keep ? in_i_ff : '0;
         rsp_q_ff <= tag.keep ? in_q_ff : '0;
         rsp_tag_ff <= tag;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_i = rsp_i_ff;
   assign rsp_out_q = rsp_q_ff;
   assign rsp_keep = rsp_tag_ff.keep;
   assign rsp_symbol_number = rsp_tag_ff.symbol_number;
   assign rsp_first_in_symbol = rsp_tag_ff.first;
   assign rsp_last_in_symbol = rsp_tag_ff.last;
   assign rsp_slot_start = rsp_tag_ff.slot_start;
   assign rsp_sync_lost = rsp_tag_ff.sync_lost;
   assign rsp_synced = rsp_tag_ff.synced;

   a_keep_synced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_keep |-> rsp_synced)
      else $error("kept sample while not synced");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_keep |-> rsp_out_i == '0 && rsp_out_q == '0
                                 && !rsp_first_in_symbol && !rsp_last_in_symbol)
      else $error("dropped sample carries data or flags");

   a_slot_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slot_start |-> rsp_first_in_symbol)
      else $error("slot start without first flag");

   a_lost_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sync_lost |-> rsp_synced && rsp_symbol_number == '0)
      else $error("sync loss did not restart frame");

   a_symno_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_symbol_number < SYMS_PER_FRAME)
      else $error("symbol number out of range");

endmodule

// ----- tb/sv/tb_ofdm_cyclic_prefix_remover.sv -----
// Self-checking testbench for the OFDM cyclic prefix remover.
`timescale 1ns / 100ps

module tb_ofdm_cyclic_prefix_remover;
   import ocpr_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_ITEMS = 1200;
   localparam int unsigned LONG_SYMBOL_ITEMS = 600;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] out_i;
      logic [SAMPLE_WIDTH-1:0] out_q;
      sample_tag_type tag;
   } sample_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_sample_i = '0;
   logic signed [SAMPLE_WIDTH-1:0] req_sample_q = '0;
   logic req_frame_mark = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_out_i;
   logic signed [SAMPLE_WIDTH-1:0] rsp_out_q;
   logic rsp_keep;
   logic [SYMNO_WIDTH-1:0] rsp_symbol_number;
   logic rsp_first_in_symbol;
   logic rsp_last_in_symbol;
   logic rsp_slot_start;
   logic rsp_sync_lost;
   logic rsp_synced;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data = '0;

   // predictor state
   cfg_type lengths = '{FFT_LENGTH_RESET, CP_NORMAL_RESET, CP_FIRST_RESET};
   logic frame_locked = 1'b0;
   logic [POS_WIDTH-1:0] sym_pos = '0;
   logic [SLOT_WIDTH-1:0] slot_idx = '0;
   logic [SYMNO_WIDTH-1:0] frame_sym = '0;

   sample_result_type pending_samples[$];
   int unsigned mismatches = 0;
   logic no_idle = 1'b0;

   ofdm_cyclic_prefix_remover i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample_i(req_sample_i),
      .req_sample_q(req_sample_q),
      .req_frame_mark(req_frame_mark),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_i(rsp_out_i),
      .rsp_out_q(rsp_out_q),
      .rsp_keep(rsp_keep),
      .rsp_symbol_number(rsp_symbol_number),
      .rsp_first_in_symbol(rsp_first_in_symbol),
      .rsp_last_in_symbol(rsp_last_in_symbol),
      .rsp_slot_start(rsp_slot_start),
      .rsp_sync_lost(rsp_sync_lost),
      .rsp_synced(rsp_synced),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic sample_result_type predict_cp_removal(
      input logic [SAMPLE_WIDTH-1:0] si,
      input logic [SAMPLE_WIDTH-1:0] sq,
      input logic mark
   );
      sample_result_type r;
      int unsigned prefix;
      int unsigned sym_len;
      r = '0;
      if (!frame_locked) begin
         if (!mark) return r;
         frame_locked = 1'b1;
         sym_pos = '0;
         slot_idx = '0;
         frame_sym = '0;
      end else if (mark && (sym_pos != 0 || slot_idx != 0 || frame_sym != 0)) begin
         r.tag.sync_lost = 1'b1;
         sym_pos = '0;
         slot_idx = '0;
         frame_sym = '0;
      end
      prefix = (slot_idx == 0) ? lengths.cp_first : lengths.cp_normal;
      sym_len = prefix + lengths.fft_length;
      if (sym_len > MAX_SYM_LEN) sym_len = MAX_SYM_LEN;
      r.tag.synced = 1'b1;
      r.tag.symbol_number = frame_sym;
      if (sym_pos >= prefix && sym_pos < sym_len) begin
         r.out_i = si;
         r.out_q = sq;
         r.tag.keep = 1'b1;
         r.tag.first = (sym_pos == prefix);
         r.tag.last = (sym_pos + 1 == sym_len);
         r.tag.slot_start = r.tag.first && (slot_idx == 0);
      end
      if (sym_pos + 1 >= sym_len) begin
         sym_pos = '0;
         slot_idx = (slot_idx + 1 >= SYMS_PER_SLOT) ? '0 : slot_idx + 1'b1;
         frame_sym = (frame_sym + 1 >= SYMS_PER_FRAME) ? '0 : frame_sym + 1'b1;
      end else begin
         sym_pos = sym_pos + 1'b1;
      end
      return r;
   endfunction

   function automatic logic at_frame_start();
      return frame_locked && sym_pos == 0 && slot_idx == 0 && frame_sym == 0;
   endfunction

   // called and returning at a falling edge
   task automatic send_sample(
      input logic [SAMPLE_WIDTH-1:0] si,
      input logic [SAMPLE_WIDTH-1:0] sq,
      input logic mark
   );
      while (!no_idle && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_i <= si;
      req_sample_q <= sq;
      req_frame_mark <= mark;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_samples.push_back(predict_cp_removal(si, sq, mark));
      @(negedge clock);
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // leaves the write enable high; the caller lowers it
   task automatic write_register(
      input logic [CSR_INDEX_WIDTH-1:0] index,
      input logic [CSR_DATA_WIDTH-1:0] data
   );
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      case (index)
         CSR_FFT_LENGTH: lengths.fft_length = data[FFT_WIDTH-1:0];
         CSR_CP_NORMAL: lengths.cp_normal = data[CP_WIDTH-1:0];
         CSR_CP_FIRST: lengths.cp_first = data[CP_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_lengths(
      input logic [CSR_DATA_WIDTH-1:0] fft,
      input logic [CSR_DATA_WIDTH-1:0] cpn,
      input logic [CSR_DATA_WIDTH-1:0] cpf
   );
      wait_for_idle();
      write_register(CSR_FFT_LENGTH, fft);
      write_register(CSR_CP_NORMAL, cpn);
      write_register(CSR_CP_FIRST, cpf);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_searching();
      send_sample(16'h8000, 16'h7FFF, 1'b0);
      send_sample(16'h7FFF, 16'h8000, 1'b0);
      send_sample(16'h0000, 16'hFFFF, 1'b0);
      send_sample(16'hFFFF, 16'h0000, 1'b0);
   endtask

   task automatic test_marks();
      send_sample(16'h1234, 16'hFEDC, 1'b1);
      set_lengths(12'd4, 12'd1, 12'd2);
      repeat (5) send_sample(16'($urandom), 16'($urandom), 1'b0);
      send_sample(16'h8000, 16'h8000, 1'b1);
      send_sample(16'h7FFF, 16'h7FFF, 1'b0);
   endtask

   task automatic test_config_mid_symbol();
      set_lengths(12'd8, 12'd2, 12'd2);
      repeat (4) send_sample(16'($urandom), 16'($urandom), 1'b0);
      set_lengths(12'd2, 12'd1, 12'd1);
      repeat (2) send_sample(16'($urandom), 16'($urandom), 1'b0);
   endtask

   task automatic test_empty_body();
      set_lengths(12'd0, 12'd2, 12'd3);
      repeat (3) send_sample(16'($urandom), 16'($urandom), 1'b0);
      set_lengths(12'd0, 12'd0, 12'd0);
      repeat (2) send_sample(16'($urandom), 16'($urandom), 1'b0);
   endtask

   task automatic test_range_limits();
      set_lengths(12'd128, 12'd256, 12'd320);
      repeat (3) send_sample(16'($urandom), 16'($urandom), 1'b0);
   endtask

   task automatic test_long_symbol();
      wait_for_idle();
      write_register(CSR_UNUSED, 12'hFFF);
      write_register(CSR_FFT_LENGTH, 12'hFFF);
      write_register(CSR_CP_NORMAL, 12'hFFF);
      write_register(CSR_CP_FIRST, 12'hFFF);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      repeat (LONG_SYMBOL_ITEMS) send_sample(16'($urandom), 16'($urandom), 1'b0);
   endtask

   task automatic test_random_frames();
      int unsigned sent;
      int unsigned phase;
      int unsigned span;
      logic mark;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         span = $urandom_range(60, 200);
         if (phase == 0) begin
            set_lengths(12'd0, 12'd0, 12'd0);
            span = 300;
         end else begin
            case ($urandom_range(9))
               0: set_lengths(12'd0, 12'd0, 12'd0);
               1: set_lengths(12'd128, 12'($urandom_range(0, 3)),
                              12'($urandom_range(0, 4)));
               default: set_lengths(12'($urandom_range(1, 8)), 12'($urandom_range(0, 3)),
                                    12'($urandom_range(0, 4)));
            endcase
         end
         no_idle = (phase == 3);
         for (int unsigned k = 0; k < span; k++) begin
            if (at_frame_start()) mark = 1'($urandom_range(1));
            else mark = ($urandom_range(99) == 0);
            send_sample(16'($urandom), 16'($urandom), mark);
            sent++;
            if (phase == 5 && k == span / 2) wait_for_idle();
         end
         no_idle = 1'b0;
         phase++;
      end
   endtask

   task automatic compare_field(
      input string field,
      input logic [15:0] want,
      input logic [15:0] got
   );
      if (want !== got) begin
         $display("%0t %s expected %0h actual %0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(negedge clock) rsp_stall <= !no_idle && ($urandom_range(99) < 22);

   always @(posedge clock) begin
      sample_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            $display("%0t unexpected transaction: expected none actual out_i %0h out_q %0h",
                     $time, rsp_out_i, rsp_out_q);
            mismatches++;
         end else begin
            want = pending_samples.pop_front();
            compare_field("out_i", want.out_i, rsp_out_i);
            compare_field("out_q", want.out_q, rsp_out_q);
            compare_field("keep", 16'(want.tag.keep), 16'(rsp_keep));
            compare_field("symbol_number", 16'(want.tag.symbol_number),
                          16'(rsp_symbol_number));
            compare_field("first_in_symbol", 16'(want.tag.first), 16'(rsp_first_in_symbol));
            compare_field("last_in_symbol", 16'(want.tag.last), 16'(rsp_last_in_symbol));
            compare_field("slot_start", 16'(want.tag.slot_start), 16'(rsp_slot_start));
            compare_field("sync_lost", 16'(want.tag.sync_lost), 16'(rsp_sync_lost));
            compare_field("synced", 16'(want.tag.synced), 16'(rsp_synced));
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[ofdm_cyclic_prefix_remover] ERROR");
      $finish;
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_searching();
      test_marks();
      test_config_mid_symbol();
      test_empty_body();
      test_range_limits();
      test_long_symbol();
      test_random_frames();
      wait_for_idle();
      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("[ofdm_cyclic_prefix_remover] OK");
      end else begin
         $display("[ofdm_cyclic_prefix_remover] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/ocpr_pkg.sv
design/ocpr_csr.sv
design/ocpr_framer.sv
design/ofdm_cyclic_prefix_remover.sv
tb/sv/tb_ofdm_cyclic_prefix_remover.sv
